FILE: rtl/bda_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds shared widths, constants and the digit helper functions; no dependencies.
package bda_pkg;

    localparam int VALUE_BITS        = 64;
    localparam int VALUE_WIDTH_DEF   = 64;
    localparam int CHAR_BITS         = 6;
    localparam int QUEUE_DEPTH       = 2;
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Decimal digits needed for 2**w - 1: floor(w * log10(2)) + 1.
    function automatic int num_digits(input int w);
        return ((w * 1233) >> 12) + 1;
    endfunction

    // Add three to a BCD digit of five or more ahead of the next shift.
    function automatic logic [3:0] dabble(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

FILE: rtl/bda_if.sv
// Channel interfaces of the binary to decimal ASCII converter.
// Depends on bda_pkg for the payload widths.
interface bda_in_if;
    logic                            valid;
    logic                            ready;
    logic [bda_pkg::VALUE_BITS-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bda_out_if;
    logic                           valid;
    logic                           ready;
    logic [bda_pkg::CHAR_BITS-1:0]  digit_char;
    logic                           last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

FILE: rtl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Depends on bda_pkg, bda_if, bda_front, bda_queue and bda_back.
//
// Takes one unsigned value per transfer on din (only the low VALUE_WIDTH bits
// count) and returns its decimal text on dout as ASCII digits, most
// significant first, with no leading zeros; zero gives a single '0'. The
// final digit of each value carries last_digit. The front end runs a
// shift-add-3 conversion of one bit per cycle and cannot accept the next
// value until the current one has been converted and handed on; that loop
// sets the sustained rate. A two-entry queue hands the packed BCD word to
// the back end, which drops leading zeros at one digit a cycle and, while
// the output is not stalled, presents one digit a cycle through a registered
// output, so it keeps pace with the front end, and output stalls do not reach
// the input until the queue fills. There is no configuration and no state
// kept between values.
module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bda_in_if.sink     din,
    bda_out_if.source  dout
);

    localparam int ND = bda_pkg::num_digits(VALUE_WIDTH);
    localparam int BW = ND * 4;

    // converted words on their way to the back end
    logic          f_valid, f_ready;
    logic [BW-1:0] f_bcd;
    logic          b_valid, b_ready;
    logic [BW-1:0] b_bcd;

    bda_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_bcd   (f_bcd)
    );

    bda_queue #(
        .WIDTH (BW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_bcd),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_bcd)
    );

    bda_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_bcd   (b_bcd),
        .dout      (dout)
    );

endmodule

FILE: rtl/bda_front.sv
// Front end: accepts a binary value and converts it to packed BCD by shift-add-3.
// Depends on bda_pkg and bda_in_if.
module bda_front #(
    parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    bda_in_if.sink                                            din,
    output logic                                              push_valid,
    input  logic                                              push_ready,
    output logic [bda_pkg::num_digits(VALUE_WIDTH)*4-1:0]     push_bcd
);

    localparam int ND = bda_pkg::num_digits(VALUE_WIDTH);
    localparam int BW = ND * 4;
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BW-1:0]          bcd_reg, bcd_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [BW-1:0]          dab;

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            dab[i*4 +: 4] = bda_pkg::dabble(bcd_reg[i*4 +: 4]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    bin_next   = din.value[VALUE_WIDTH-1:0];
                    bcd_next   = '0;
                    cnt_next   = CW'(VALUE_WIDTH);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // shift one bit into the adjusted BCD word
                bcd_next = {dab[BW-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign din.ready  = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_bcd   = bcd_reg;

    a_conv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (cnt_reg != '0))
        else $error("conversion running with zero bits left");

endmodule

FILE: rtl/bda_queue.sv
// Short queue of converted BCD words between the front and back ends.
// Depends on bda_pkg for its depth.
module bda_queue #(
    parameter int WIDTH = 80
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = bda_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] ent_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = ent_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

FILE: rtl/bda_back.sv
// Back end: walks a BCD word from the top digit, drops leading zeros and emits ASCII.
// Depends on bda_pkg and bda_out_if.
module bda_back #(
    parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          pop_valid,
    output logic                                          pop_ready,
    input  logic [bda_pkg::num_digits(VALUE_WIDTH)*4-1:0] pop_bcd,
    bda_out_if.source                                     dout
);

    localparam int ND = bda_pkg::num_digits(VALUE_WIDTH);
    localparam int BW = ND * 4;
    localparam int LW = $clog2(ND + 1);

    logic                           busy_reg, busy_next;
    logic                           started_reg, started_next;
    logic [BW-1:0]                  bcd_reg, bcd_next;
    logic [LW-1:0]                  left_reg, left_next;
    logic                           out_valid_reg, out_valid_next;
    logic [bda_pkg::CHAR_BITS-1:0]  out_char_reg, out_char_next;
    logic                           out_last_reg, out_last_next;
    logic [3:0]                     top;
    logic                           skip, can_emit, emit;

    assign top       = bcd_reg[BW-1 -: 4];
    assign skip      = !started_reg && (top == 4'd0) && (left_reg > LW'(1));
    assign can_emit  = !out_valid_reg || dout.ready;
    assign emit      = busy_reg && !skip && can_emit;
    assign pop_ready = !busy_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        started_next   = started_reg;
        bcd_next       = bcd_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (!busy_reg)
        begin
            if (pop_valid)
            begin
                busy_next    = 1'b1;
                started_next = 1'b0;
                bcd_next     = pop_bcd;
                left_next    = LW'(ND);
            end
        end
        else if (skip)
        begin
            bcd_next  = {bcd_reg[BW-5:0], 4'd0};
            left_next = left_reg - LW'(1);
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = bda_pkg::ASCII_ZERO + {2'b00, top};
            out_last_next  = (left_reg == LW'(1));
            started_next   = 1'b1;
            bcd_next       = {bcd_reg[BW-5:0], 4'd0};
            left_next      = left_reg - LW'(1);
            if (left_reg == LW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            started_reg   <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            started_reg   <= started_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign dout.valid      = out_valid_reg;
    assign dout.digit_char = out_char_reg;
    assign dout.last_digit = out_last_reg;

    a_busy_left: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != '0))
        else $error("back end busy with no digits left");

    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !started_reg && (left_reg != LW'(1))) |-> (top != 4'd0))
        else $error("leading zero emitted");

endmodule

FILE: tb/binary_to_decimal_ascii_tb.sv
// Self-checking testbench for binary_to_decimal_ascii: directed table, then random values.
// Depends on bda_pkg and the channel interfaces in bda_if; digits are predicted locally.
module binary_to_decimal_ascii_tb;

    localparam int VALUE_BITS        = bda_pkg::VALUE_BITS;
    localparam int CHAR_BITS         = bda_pkg::CHAR_BITS;
    localparam logic [5:0] ASCII_ZERO = bda_pkg::ASCII_ZERO;

    localparam int CONV_WIDTH   = bda_pkg::VALUE_WIDTH_DEF;
    localparam int MAX_CHARS    = 20;
    localparam int RANDOM_ITEMS = 208;
    localparam int DIR_ROWS     = 22;
    localparam int HOLD_AFTER   = 300;   // results seen before the long output stall
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;   // settle time once nothing is outstanding

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } digit_t;

    logic clk;
    logic rst_n;

    bda_in_if  din ();
    bda_out_if dout ();

    binary_to_decimal_ascii #(
        .VALUE_WIDTH (CONV_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    // Digits still owed by the block, oldest first.
    digit_t pending_digits[$];

    int  mismatches   = 0;
    int  results_seen = 0;
    bit  calm         = 1'b0;   // set to switch off random idling on both sides

    // Directed table. An empty text means the row is checked against the predictor.
    logic [VALUE_BITS-1:0] dir_value [DIR_ROWS] = '{
        64'd0,
        64'd1,
        64'd9,
        64'd10,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000,
        64'd4294967295,
        64'd4294967296,
        64'd99,
        64'd100,
        64'd7,
        64'd42,
        64'd255,
        64'd1000000,
        64'd9999999999999999999,
        64'd10000000000000000000,
        64'd12345678901234567890,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'hFFFF_FFFF_FFFF_FFFE,
        64'd999999999,
        64'd0
    };

    string dir_text [DIR_ROWS] = '{
        "0",
        "1",
        "9",
        "10",
        "18446744073709551615",
        "9223372036854775808",
        "4294967295",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "0"
    };

    // Clock: period of 2 time units.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Give up after a generous fixed time; a correct run needs a small fraction of it.
    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Predict the decimal text of one value and queue its digits, most significant first.
    task automatic queue_decimal_digits(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] rem;
        logic [VALUE_BITS-1:0] width_mask;
        logic [3:0]            rev [MAX_CHARS];
        int                    n;
        digit_t                d;
        width_mask = (CONV_WIDTH >= VALUE_BITS) ? '1
                                                : ((64'd1 << CONV_WIDTH) - 64'd1);
        rem = v & width_mask;
        n   = 0;
        do
        begin
            rev[n] = 4'(rem % 64'd10);
            n++;
            rem = rem / 64'd10;
        end while (rem != 0 && n < MAX_CHARS);
        for (int k = 0; k < n; k++)
        begin
            d.ch   = ASCII_ZERO + CHAR_BITS'(rev[n - 1 - k]);
            d.last = (k == n - 1);
            pending_digits.push_back(d);
        end
    endtask

    // Queue digits read straight from a typed-in decimal string.
    task automatic queue_text_digits(input string s);
        digit_t d;
        for (int i = 0; i < s.len(); i++)
        begin
            d.ch   = CHAR_BITS'(s[i]);
            d.last = (i == s.len() - 1);
            pending_digits.push_back(d);
        end
    endtask

    // Offer one value on din and hold it until the transfer happens. Expectations are
    // queued at the accepting edge, so they always lead the block's first digit.
    task automatic offer_value(input logic [VALUE_BITS-1:0] v, input string text);
        // Idle a few cycles now and then, with noise on the payload.
        while (!calm && $urandom_range(99) < 6)
        begin
            @(negedge clk);
            din.valid = 1'b0;
            din.value = {$urandom, $urandom};
            @(posedge clk);
        end
        @(negedge clk);
        din.valid = 1'b1;
        din.value = v;
        do
            @(posedge clk);
        while (!din.ready);
        if (text.len() != 0)
            queue_text_digits(text);
        else
            queue_decimal_digits(v);
    endtask

    // Wait at the input until every outstanding digit has come back.
    task automatic pause_until_drained();
        @(negedge clk);
        din.valid = 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
    endtask

    // Random value: mostly a random bit length, sometimes hugging a power of ten.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] p;
        int                    len;
        int                    k;
        if ($urandom_range(7) == 0)
        begin
            k = $urandom_range(0, 19);
            p = 64'd1;
            for (int i = 0; i < k; i++)
                p = p * 64'd10;
            v = p + 64'($urandom_range(0, 2)) - 64'd1;
        end
        else
        begin
            len = $urandom_range(1, VALUE_BITS);
            v   = {$urandom, $urandom};
            if (len < VALUE_BITS)
                v = v & ((64'd1 << len) - 64'd1);
        end
        return v;
    endfunction

    // Receiver: drive ready at the falling edge. Idle at random, except in the calm
    // stretch, and hold off once for a long run of cycles so the block backs up.
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left  = 0;
        hold_done  = 1'b0;
        dout.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                dout.ready = 1'b0;
                hold_left--;
            end
            else
                dout.ready = calm || ($urandom_range(99) >= 6);
        end
    end

    // Checker: compare each digit transfer with the oldest expectation.
    initial
    begin
        digit_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && dout.valid && dout.ready)
            begin
                results_seen++;
                if (pending_digits.size() == 0)
                    flag_mismatch($sformatf("unexpected digit %0d last %0b",
                                            dout.digit_char, dout.last_digit));
                else
                begin
                    want = pending_digits.pop_front();
                    if (dout.digit_char !== want.ch)
                        flag_mismatch($sformatf("digit_char %0d, want %0d",
                                                dout.digit_char, want.ch));
                    if (dout.last_digit !== want.last)
                        flag_mismatch($sformatf("last_digit %0b, want %0b",
                                                dout.last_digit, want.last));
                end
            end
        end
    end

    // Sender: reset, directed table, then random values; drain and report.
    initial
    begin
        din.valid = 1'b0;
        din.value = '0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            offer_value(dir_value[r], dir_text[r]);

        // Let everything come back before the random part.
        pause_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // A stretch with no idling on either side.
            calm = (i >= 150 && i < 200);
            if (i == 115)
                pause_until_drained();
            offer_value(pick_value(), "");
        end
        calm = 1'b0;

        @(negedge clk);
        din.valid = 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
